// File: rtl/ccd_pkg.sv
// ccd_pkg: shared types and constants for the capped cylinder distance unit
// no dependencies; imported by every module of the block
package ccd_pkg;

  // rounding position of the Q1.16 axis products
  localparam int AXIS_FRAC = 16;
  // 1: distance negative inside, 0: positive inside
  localparam int NEGATIVE_INSIDE = 1;
  // root bits of the pipelined square root, one per stage
  localparam int SQRT_STAGES = 32;
  localparam int RAD_W = 2 * SQRT_STAGES;
  localparam int ROOT_W = SQRT_STAGES;
  // width of the rounded axial projection
  localparam int PARA_W = 37;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [17:0] axis_t;
  typedef logic [30:0] len_t;

  // configuration register indices
  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_AXIS_X      = 3'd3,
    CFG_AXIS_Y      = 3'd4,
    CFG_AXIS_Z      = 3'd5,
    CFG_RADIUS      = 3'd6,
    CFG_HALF_LENGTH = 3'd7
  } cfg_idx_e;

  // region codes of a result
  typedef enum logic [1:0] {
    REG_INSIDE = 2'd0,
    REG_CAP    = 2'd1,
    REG_WALL   = 2'd2,
    REG_CORNER = 2'd3
  } region_e;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic [1:0]         region;
  } result_t;

  // side data travelling with the perpendicular square root
  typedef struct packed {
    logic                     huge;
    logic signed [PARA_W-1:0] para;
  } front_t;

  // side data travelling with the corner square root
  typedef struct packed {
    region_e            region;
    logic signed [38:0] rsel;
  } back_t;

endpackage

// File: rtl/ccd_sqrt.sv
// ccd_sqrt: pipelined integer square root, one root bit per stage
// depends on ccd_pkg
module ccd_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [ccd_pkg::RAD_W-1:0] radicand_i,
  output logic                     valid_o,
  output logic [ccd_pkg::ROOT_W-1:0] root_o
);
  import ccd_pkg::*;

  logic [RAD_W-1:0]  rem_q   [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q  [SQRT_STAGES];
  logic              valid_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    logic [RAD_W+1:0]  trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = valid_q[k-1];
    end

    // try setting root bit B: (root + 2^B)^2 - root^2
    assign trial = ((RAD_W+2)'(root_in) << (B + 1)) | ((RAD_W+2)'(1) << (2 * B));
    assign fit   = (RAD_W+2)'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fit ? rem_in - trial[RAD_W-1:0] : rem_in;
      root_q[k] <= fit ? (root_in | (ROOT_W'(1) << B)) : root_in;
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];

endmodule

// File: rtl/ccd_front.sv
// ccd_front: offset, axial projection and perpendicular sum of squares
// depends on ccd_pkg; seven register stages
module ccd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  ccd_pkg::point_t           point_i,
  input  ccd_pkg::coord_t           center_i [3],
  input  ccd_pkg::axis_t            axis_i [3],
  output logic                      valid_o,
  output logic [ccd_pkg::RAD_W-1:0] radicand_o,
  output ccd_pkg::front_t           side_o
);
  import ccd_pkg::*;

  coord_t pt [3];
  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  logic [6:0] v_q;
  logic signed [32:0] d1_q [3];
  logic signed [32:0] d2_q [3];
  logic signed [32:0] d3_q [3];
  logic signed [32:0] d4_q [3];
  logic signed [50:0] m2_q [3];
  logic signed [PARA_W-1:0] para3_q, para4_q, para5_q, para6_q;
  logic signed [54:0] q4_q [3];
  logic [31:0] o5_q [3];
  logic huge5_q, huge6_q;
  logic [63:0] sq6_q [3];

  logic signed [52:0] psum;
  logic signed [54:0] qrnd [3];
  logic signed [38:0] qsh [3];
  logic signed [39:0] e5 [3];
  logic [39:0] oabs [3];
  logic [2:0] over;
  logic [65:0] ssum;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // axial projection rounded half up
  assign psum = 53'(m2_q[0]) + 53'(m2_q[1]) + 53'(m2_q[2]) + (53'sd1 <<< (AXIS_FRAC - 1));

  // perpendicular components and their magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qrnd[i] = q4_q[i] + (55'sd1 <<< (AXIS_FRAC - 1));
      qsh[i]  = 39'(qrnd[i] >>> AXIS_FRAC);
      e5[i]   = 40'(d4_q[i]) - 40'(qsh[i]);
      oabs[i] = e5[i][39] ? 40'(-e5[i]) : 40'(e5[i]);
      over[i] = |oabs[i][39:32];
    end
  end

  assign ssum = 66'(sq6_q[0]) + 66'(sq6_q[1]) + 66'(sq6_q[2]);

  // datapath stages
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= 33'(pt[i]) - 33'(center_i[i]);
      m2_q[i] <= 51'(d1_q[i]) * 51'(axis_i[i]);
      d2_q[i] <= d1_q[i];
      d3_q[i] <= d2_q[i];
      q4_q[i] <= 55'(para3_q) * 55'(axis_i[i]);
      d4_q[i] <= d3_q[i];
      o5_q[i] <= oabs[i][31:0];
      sq6_q[i] <= 64'(o5_q[i]) * 64'(o5_q[i]);
    end
    para3_q <= PARA_W'(psum >>> AXIS_FRAC);
    para4_q <= para3_q;
    para5_q <= para4_q;
    para6_q <= para5_q;
    huge5_q <= |over;
    huge6_q <= huge5_q;
    radicand_o  <= ssum[RAD_W-1:0];
    side_o.huge <= huge6_q | (|ssum[65:RAD_W]);
    side_o.para <= para6_q;
  end

  assign valid_o = v_q[6];

endmodule

// File: rtl/capped_cylinder_distance_unit.sv
// capped_cylinder_distance_unit: signed distance of a point to a capped cylinder
// a point passes the front end, the perpendicular root, the selection stages, the corner root and the result register
// throughput: one point per cycle; two 32-stage square root pipelines set the depth
// busy_o is always low, the pipeline never stalls
// reset clears the valid bits and loads the default unit cylinder along z
// depends on ccd_pkg, ccd_front, ccd_sqrt
module capped_cylinder_distance_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ccd_pkg::point_t  point_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_addr_i,
  input  logic [31:0]      cfg_wdata_i,
  output logic             result_valid_o,
  output ccd_pkg::result_t result_o
);
  import ccd_pkg::*;

  coord_t center_q [3];
  axis_t  axis_q [3];
  len_t   radius_q, half_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      axis_q[0]   <= '0;
      axis_q[1]   <= '0;
      axis_q[2]   <= axis_t'(1) <<< AXIS_FRAC;
      radius_q    <= len_t'(1) << 16;
      half_q      <= len_t'(1) << 16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CENTER_X:    center_q[0] <= cfg_wdata_i;
        CFG_CENTER_Y:    center_q[1] <= cfg_wdata_i;
        CFG_CENTER_Z:    center_q[2] <= cfg_wdata_i;
        CFG_AXIS_X:      axis_q[0]   <= cfg_wdata_i[17:0];
        CFG_AXIS_Y:      axis_q[1]   <= cfg_wdata_i[17:0];
        CFG_AXIS_Z:      axis_q[2]   <= cfg_wdata_i[17:0];
        CFG_RADIUS:      radius_q    <= cfg_wdata_i[30:0];
        CFG_HALF_LENGTH: half_q      <= cfg_wdata_i[30:0];
        default:         ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // front end
  logic             fr_valid;
  logic [RAD_W-1:0] fr_rad;
  front_t           fr_side;

  ccd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .point_i    (point_i),
    .center_i   (center_q),
    .axis_i     (axis_q),
    .valid_o    (fr_valid),
    .radicand_o (fr_rad),
    .side_o     (fr_side)
  );

  // perpendicular distance root
  logic              s1_valid;
  logic [ROOT_W-1:0] s1_root;
  front_t            side1_q [SQRT_STAGES];

  ccd_sqrt u_sqrt_perp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fr_valid),
    .radicand_i (fr_rad),
    .valid_o    (s1_valid),
    .root_o     (s1_root)
  );

  always_ff @(posedge clk_i) begin
    side1_q[0] <= fr_side;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      side1_q[k] <= side1_q[k-1];
    end
  end

  logic [3:0] bv_q;
  logic signed [33:0] f_q;
  logic signed [37:0] g_q;
  region_e reg2_q, reg3_q, reg4_q;
  logic signed [38:0] rsel2_q, rsel3_q, rsel4_q;
  logic [31:0] fu_q, gu_q;
  logic [63:0] fsq_q, gsq_q, csum_q;

  logic [32:0] ortho;
  logic [PARA_W-1:0] pabs;
  front_t s1_side;
  logic f_pos, g_pos;
  region_e reg_d;
  logic signed [38:0] rsel_d;
  logic [31:0] fu_d, gu_d;

  assign s1_side = side1_q[SQRT_STAGES-1];
  assign ortho   = s1_side.huge ? (33'd1 << 32) : {1'b0, s1_root};
  assign pabs    = s1_side.para[PARA_W-1] ? PARA_W'(-s1_side.para) : PARA_W'(s1_side.para);

  // feature selection
  always_comb begin
    f_pos = !f_q[33] && (f_q != '0);
    g_pos = !g_q[37] && (g_q != '0);
    fu_d  = (f_q > 34'sd2147483648) ? 32'h8000_0000 : f_q[31:0];
    gu_d  = (g_q > 38'sd2147483648) ? 32'h8000_0000 : g_q[31:0];
    if (!f_pos && !g_pos) begin
      reg_d  = REG_INSIDE;
      rsel_d = (38'(f_q) >= g_q) ? 39'(f_q) : 39'(g_q);
    end else if (!f_pos) begin
      reg_d  = REG_CAP;
      rsel_d = 39'(g_q);
    end else if (!g_pos) begin
      reg_d  = REG_WALL;
      rsel_d = 39'(f_q);
    end else begin
      reg_d  = REG_CORNER;
      rsel_d = '0;
    end
  end

  // back end valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      bv_q <= {bv_q[2:0], s1_valid};
    end
  end

  // wall and cap distances, selection, corner squares and sum
  always_ff @(posedge clk_i) begin
    f_q     <= $signed({1'b0, ortho}) - $signed({3'b000, radius_q});
    g_q     <= $signed({1'b0, pabs}) - $signed({7'b0, half_q});
    reg2_q  <= reg_d;
    rsel2_q <= rsel_d;
    fu_q    <= fu_d;
    gu_q    <= gu_d;
    fsq_q   <= 64'(fu_q) * 64'(fu_q);
    gsq_q   <= 64'(gu_q) * 64'(gu_q);
    reg3_q  <= reg2_q;
    rsel3_q <= rsel2_q;
    csum_q  <= fsq_q + gsq_q;
    reg4_q  <= reg3_q;
    rsel4_q <= rsel3_q;
  end

  // corner root
  logic              s2_valid;
  logic [ROOT_W-1:0] s2_root;
  back_t             side2_q [SQRT_STAGES];
  back_t             s2_side;

  ccd_sqrt u_sqrt_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (bv_q[3]),
    .radicand_i (csum_q),
    .valid_o    (s2_valid),
    .root_o     (s2_root)
  );

  always_ff @(posedge clk_i) begin
    side2_q[0] <= '{region: reg4_q, rsel: rsel4_q};
    for (int k = 1; k < SQRT_STAGES; k++) begin
      side2_q[k] <= side2_q[k-1];
    end
  end

  assign s2_side = side2_q[SQRT_STAGES-1];

  // sign convention and saturation
  logic signed [39:0] r_d;
  logic signed [31:0] dist_d;

  always_comb begin
    r_d = (s2_side.region == REG_CORNER) ? 40'($signed({1'b0, s2_root}))
                                          : 40'(s2_side.rsel);
    if (NEGATIVE_INSIDE == 0) begin
      r_d = -r_d;
    end
    if (r_d > 40'sd2147483647) begin
      dist_d = 32'sh7FFF_FFFF;
    end else if (r_d < -40'sd2147483648) begin
      dist_d = 32'sh8000_0000;
    end else begin
      dist_d = r_d[31:0];
    end
  end

  // result transfer register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.distance <= dist_d;
    result_o.region   <= s2_side.region;
  end

endmodule
